### src/bpa_pkg.sv
// Shared types, constants and helpers for the buddy page allocator.
package bpa_pkg;

    localparam int TOP_ORDER  = 10;
    localparam int PAGE_BYTES = 64;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int ID_WIDTH   = 16;
    localparam int POOL_PAGES = 1 << TOP_ORDER;
    localparam int PAGE_W     = TOP_ORDER;
    localparam int LINK_W     = TOP_ORDER + 1;
    localparam int ORD_W      = $clog2(TOP_ORDER + 1);
    localparam int CFG_W      = 4;
    localparam int SIZE_W     = 24;
    localparam int PAGES_W    = SIZE_W + 1 - PAGE_SHIFT;
    localparam int REQ_W      = $clog2(PAGES_W + 1);
    localparam int ADDR_W     = 16;
    localparam int IN_W       = 48;
    localparam int OUT_W      = 40;
    localparam int POOL_RESET = 10;

    localparam logic [LINK_W-1:0] NIL_PAGE = LINK_W'(POOL_PAGES);

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_NOFIT = 2'd1,
        STAT_BADID = 2'd2,
        STAT_NOIDS = 2'd3
    } stat_t;

    typedef enum logic [1:0] {
        CMD_ALLOC,
        CMD_FREE,
        CMD_QUERY,
        CMD_BAD
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [REQ_W-1:0]     req;
        logic [ID_WIDTH-1:0]  rid;
    } cmd_t;

    typedef struct packed {
        logic                 used;
        logic [ORD_W-1:0]     ord;
        logic [ID_WIDTH-1:0]  id;
    } blk_ent_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_SRCH,
        S_ALLOC_POP,
        S_ALLOC_SPLIT,
        S_SCAN,
        S_MERGE,
        S_WALK,
        S_WALK_NEXT,
        S_UNLINK,
        S_PUSH,
        S_RESP
    } state_t;

    function automatic logic [ADDR_W-1:0] page_addr(input logic [PAGE_W-1:0] p);
        logic [PAGE_W+PAGE_SHIFT-1:0] w;
        w = {p, {PAGE_SHIFT{1'b0}}};
        return ADDR_W'(w);
    endfunction

endpackage

### src/buddy_page_allocator_core.sv
// Top level of the buddy page allocator.
//
//  channel  dir  handshake           content
//  s_       in   s_tvalid/s_tready   s_tdata: op, size_bytes, request_id
//  m_       out  m_tvalid/m_tready   m_tdata: status, block_id, address
//  cfg_     in   cfg_we              cfg_wdata: pool_order
//
// Allocate: search the free lists upward from the requested order, pop the block found and split it down.
// Free/query: a block-table scan that stops at the owner page; free then merges level by level,
//   walking the free list of each level for the buddy, and pushes the merged block.
// Reset and each cfg write start a clear of the page tables;
//   s_tready is low meanwhile. A two-deep queue decouples input from the
//   sequencer and one result register decouples it from m_tready.
module buddy_page_allocator_core import bpa_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // op[1:0], size_bytes[25:2], request_id[41:26]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // status[1:0], block_id[17:2], address[33:18]
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;
    logic init_busy;

    bpa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .init_busy (init_busy),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop)
    );

    bpa_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

### src/bpa_front.sv
// Front end: accepts beats, classifies them and queues commands.
module bpa_front import bpa_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,
    input  logic            init_busy,
    output logic            q_valid,
    output cmd_t            q_cmd,
    input  logic            q_pop
);

    logic [1:0]         op;
    logic [SIZE_W-1:0]  size;
    logic [SIZE_W:0]    sum;
    logic [PAGES_W-1:0] pages;
    logic [PAGES_W-1:0] pm1;
    logic [REQ_W-1:0]   req;
    cmd_t               cmd_in;
    logic               push;

    cmd_t       q_mem_reg [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign op    = s_tdata[1:0];
    assign size  = s_tdata[SIZE_W+1:2];
    assign sum   = {1'b0, size} + (SIZE_W+1)'(PAGE_BYTES - 1);
    assign pages = sum[SIZE_W:PAGE_SHIFT];
    assign pm1   = pages - PAGES_W'(1);

    always_comb begin
        req = '0;
        for (int i = 0; i < PAGES_W; i++) begin
            if (pm1[i]) begin
                req = REQ_W'(i + 1);
            end
        end
    end

    always_comb begin
        cmd_in.req = req;
        cmd_in.rid = s_tdata[SIZE_W+ID_WIDTH+1:SIZE_W+2];
        unique case (op)
            OP_ALLOC: cmd_in.kind = (size == '0) ? CMD_BAD : CMD_ALLOC;
            OP_FREE:  cmd_in.kind = CMD_FREE;
            OP_QUERY: cmd_in.kind = CMD_QUERY;
            default:  cmd_in.kind = CMD_BAD;
        endcase
    end

    assign s_tready = (cnt_reg != 2'd2) && !init_busy;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

### src/bpa_back.sv
// Back end: free lists, block table, allocate/free/query sequencer, result register.
module bpa_back import bpa_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             q_valid,
    input  cmd_t             q_cmd,
    output logic             q_pop,
    output logic             init_busy,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    state_t state_reg, state_next;

    logic [ORD_W-1:0]    pool_reg, pool_next;
    logic [PAGE_W-1:0]   clr_reg, clr_next;
    logic [ORD_W-1:0]    cur_reg, cur_next;
    logic [ORD_W-1:0]    req_reg, req_next;
    logic [PAGE_W-1:0]   blk_reg, blk_next;
    logic [PAGE_W-1:0]   base_reg, base_next;
    logic [PAGE_W-1:0]   bud_reg, bud_next;
    logic [ORD_W-1:0]    ord_reg, ord_next;
    logic [LINK_W-1:0]   walk_reg, walk_next;
    logic [LINK_W-1:0]   prev_reg, prev_next;
    logic [PAGE_W:0]     scan_reg, scan_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [PAGE_W-1:0]   rd_page_reg, rd_page_next;
    logic [ID_WIDTH-1:0] rid_reg, rid_next;
    logic                is_free_reg, is_free_next;
    logic [ID_WIDTH:0]   id_cnt_reg, id_cnt_next;
    stat_t               res_status_reg, res_status_next;
    logic [ID_WIDTH-1:0] res_id_reg, res_id_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic                out_vld_reg, out_vld_next;
    logic [OUT_W-1:0]    out_data_reg, out_data_next;

    logic [LINK_W-1:0]   head_reg [0:TOP_ORDER];
    logic [LINK_W-1:0]   nxt_mem [0:POOL_PAGES-1];
    blk_ent_t            blk_mem [0:POOL_PAGES-1];
    logic [LINK_W-1:0]   nxt_rd_reg;
    blk_ent_t            blk_rd_reg;

    logic [ORD_W-1:0]    head_idx;
    logic [LINK_W-1:0]   head_rd;
    logic                head_we;
    logic [ORD_W-1:0]    head_widx;
    logic [LINK_W-1:0]   head_wdata;
    logic                nxt_we;
    logic [PAGE_W-1:0]   nxt_waddr;
    logic [LINK_W-1:0]   nxt_wdata;
    logic [PAGE_W-1:0]   nxt_raddr;
    logic                blk_we;
    logic [PAGE_W-1:0]   blk_waddr;
    blk_ent_t            blk_wdata;

    logic [ORD_W-1:0]    cfg_sat;
    logic [PAGE_W:0]     pool_pages;
    logic [ORD_W-1:0]    cur_dn;
    logic [PAGE_W-1:0]   split_pg;
    logic w_over, w_exh, srch_fail, head_empty, split_more, scan_issue;
    logic scan_hit, scan_miss, merge_more, walk_nil, walk_hit, out_free, clr_last;

    assign cfg_sat    = (cfg_wdata > CFG_W'(TOP_ORDER)) ? ORD_W'(TOP_ORDER)
                                                        : ORD_W'(cfg_wdata);
    assign pool_pages = (PAGE_W+1)'(1) << pool_reg;
    assign cur_dn     = cur_reg - ORD_W'(1);
    assign split_pg   = blk_reg | (PAGE_W'(1) << cur_dn);

    always_comb begin
        case (state_reg) inside
            S_ALLOC_SPLIT:             head_idx = cur_dn;
            S_MERGE, S_UNLINK, S_PUSH: head_idx = ord_reg;
            default:                   head_idx = cur_reg;
        endcase
    end
    assign head_rd = (head_idx <= ORD_W'(TOP_ORDER)) ? head_reg[head_idx] : NIL_PAGE;

    assign w_over     = q_cmd.req > REQ_W'(pool_reg);
    assign w_exh      = id_cnt_reg[ID_WIDTH];
    assign srch_fail  = cur_reg > pool_reg;
    assign head_empty = head_rd == NIL_PAGE;
    assign split_more = cur_reg > req_reg;
    assign scan_issue = scan_reg < pool_pages;
    assign scan_hit   = rd_vld_reg && blk_rd_reg.used && (blk_rd_reg.id == rid_reg);
    assign scan_miss  = !scan_issue && !rd_vld_reg;
    assign merge_more = ord_reg < pool_reg;
    assign walk_nil   = walk_reg == NIL_PAGE;
    assign walk_hit   = walk_reg[PAGE_W-1:0] == bud_reg;
    assign out_free   = !out_vld_reg || m_tready;
    assign clr_last   = &clr_reg;

    assign init_busy = (state_reg == S_CLEAR);
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = out_data_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: state_next = clr_last ? S_IDLE : S_CLEAR;
            S_IDLE: begin
                if (q_valid) begin
                    unique case (q_cmd.kind) inside
                        CMD_ALLOC: state_next = (w_over || w_exh) ? S_RESP : S_ALLOC_SRCH;
                        CMD_FREE, CMD_QUERY: state_next = S_SCAN;
                        default: state_next = S_RESP;
                    endcase
                end
            end
            S_ALLOC_SRCH: begin
                if (srch_fail) state_next = S_RESP;
                else if (!head_empty) state_next = S_ALLOC_POP;
            end
            S_ALLOC_POP:   state_next = S_ALLOC_SPLIT;
            S_ALLOC_SPLIT: state_next = split_more ? S_ALLOC_SPLIT : S_RESP;
            S_SCAN: begin
                if (scan_hit) state_next = is_free_reg ? S_MERGE : S_RESP;
                else if (scan_miss) state_next = S_RESP;
            end
            S_MERGE: state_next = merge_more ? S_WALK : S_PUSH;
            S_WALK: begin
                if (walk_nil) state_next = S_PUSH;
                else if (walk_hit) state_next = S_UNLINK;
                else state_next = S_WALK_NEXT;
            end
            S_WALK_NEXT: state_next = S_WALK;
            S_UNLINK:    state_next = S_MERGE;
            S_PUSH:      state_next = S_RESP;
            S_RESP:      state_next = out_free ? S_IDLE : S_RESP;
            default:     state_next = S_CLEAR;
        endcase
        if (cfg_we) begin
            state_next = S_CLEAR;
        end
    end

    // datapath and memory controls
    always_comb begin
        pool_next       = pool_reg;
        clr_next        = clr_reg;
        cur_next        = cur_reg;
        req_next        = req_reg;
        blk_next        = blk_reg;
        base_next       = base_reg;
        bud_next        = bud_reg;
        ord_next        = ord_reg;
        walk_next       = walk_reg;
        prev_next       = prev_reg;
        scan_next       = scan_reg;
        rd_vld_next     = 1'b0;
        rd_page_next    = rd_page_reg;
        rid_next        = rid_reg;
        is_free_next    = is_free_reg;
        id_cnt_next     = id_cnt_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_addr_next   = res_addr_reg;
        out_vld_next    = out_vld_reg && !m_tready;
        out_data_next   = out_data_reg;
        q_pop      = 1'b0;
        head_we    = 1'b0;
        head_widx  = ord_reg;
        head_wdata = head_rd;
        nxt_we     = 1'b0;
        nxt_waddr  = base_reg;
        nxt_wdata  = head_rd;
        nxt_raddr  = walk_reg[PAGE_W-1:0];
        blk_we     = 1'b0;
        blk_waddr  = rd_page_reg;
        blk_wdata  = '0;

        unique case (state_reg)
            S_CLEAR: begin
                nxt_we    = 1'b1;
                nxt_waddr = clr_reg;
                nxt_wdata = NIL_PAGE;
                blk_we    = 1'b1;
                blk_waddr = clr_reg;
                clr_next  = clr_reg + PAGE_W'(1);
            end
            S_IDLE: begin
                if (q_valid) begin
                    q_pop           = 1'b1;
                    req_next        = ORD_W'(q_cmd.req);
                    cur_next        = ORD_W'(q_cmd.req);
                    rid_next        = q_cmd.rid;
                    is_free_next    = (q_cmd.kind == CMD_FREE);
                    scan_next       = '0;
                    res_status_next = STAT_OK;
                    res_id_next     = '0;
                    res_addr_next   = '0;
                    unique case (q_cmd.kind) inside
                        CMD_ALLOC: begin
                            if (w_over) res_status_next = STAT_NOFIT;
                            else if (w_exh) res_status_next = STAT_NOIDS;
                        end
                        CMD_FREE, CMD_QUERY: ;
                        default: res_status_next = STAT_NOFIT;
                    endcase
                end
            end
            S_ALLOC_SRCH: begin
                nxt_raddr = head_rd[PAGE_W-1:0];
                if (srch_fail) begin
                    res_status_next = STAT_NOFIT;
                end else if (head_empty) begin
                    cur_next = cur_reg + ORD_W'(1);
                end else begin
                    blk_next = head_rd[PAGE_W-1:0];
                end
            end
            S_ALLOC_POP: begin
                head_we    = 1'b1;
                head_widx  = cur_reg;
                head_wdata = nxt_rd_reg;
            end
            S_ALLOC_SPLIT: begin
                if (split_more) begin
                    nxt_we     = 1'b1;
                    nxt_waddr  = split_pg;
                    nxt_wdata  = head_rd;
                    head_we    = 1'b1;
                    head_widx  = cur_dn;
                    head_wdata = {1'b0, split_pg};
                    cur_next   = cur_dn;
                end else begin
                    blk_we         = 1'b1;
                    blk_waddr      = blk_reg;
                    blk_wdata.used = 1'b1;
                    blk_wdata.ord  = req_reg;
                    blk_wdata.id   = id_cnt_reg[ID_WIDTH-1:0];
                    res_id_next    = id_cnt_reg[ID_WIDTH-1:0];
                    res_addr_next  = page_addr(blk_reg);
                    id_cnt_next    = id_cnt_reg + (ID_WIDTH+1)'(1);
                end
            end
            S_SCAN: begin
                rd_vld_next  = scan_issue;
                rd_page_next = scan_reg[PAGE_W-1:0];
                if (scan_issue) begin
                    scan_next = scan_reg + (PAGE_W+1)'(1);
                end
                if (scan_hit) begin
                    if (is_free_reg) begin
                        blk_we    = 1'b1;
                        blk_waddr = rd_page_reg;
                        base_next = rd_page_reg;
                        ord_next  = blk_rd_reg.ord;
                    end else begin
                        res_addr_next = page_addr(rd_page_reg);
                    end
                end else if (scan_miss) begin
                    res_status_next = STAT_BADID;
                end
            end
            S_MERGE: begin
                if (merge_more) begin
                    bud_next  = base_reg ^ (PAGE_W'(1) << ord_reg);
                    walk_next = head_rd;
                    prev_next = NIL_PAGE;
                end
            end
            S_WALK: begin
                if (!walk_nil) begin
                    if (walk_hit) begin
                        nxt_raddr = bud_reg;
                    end else begin
                        prev_next = walk_reg;
                    end
                end
            end
            S_WALK_NEXT: walk_next = nxt_rd_reg;
            S_UNLINK: begin
                if (prev_reg == NIL_PAGE) begin
                    head_we    = 1'b1;
                    head_widx  = ord_reg;
                    head_wdata = nxt_rd_reg;
                end else begin
                    nxt_we    = 1'b1;
                    nxt_waddr = prev_reg[PAGE_W-1:0];
                    nxt_wdata = nxt_rd_reg;
                end
                base_next = base_reg & ~(PAGE_W'(1) << ord_reg);
                ord_next  = ord_reg + ORD_W'(1);
            end
            S_PUSH: begin
                nxt_we     = 1'b1;
                nxt_waddr  = base_reg;
                nxt_wdata  = head_rd;
                head_we    = 1'b1;
                head_widx  = ord_reg;
                head_wdata = {1'b0, base_reg};
            end
            S_RESP: begin
                if (out_free) begin
                    out_vld_next  = 1'b1;
                    out_data_next = OUT_W'({res_addr_reg, res_id_reg, res_status_reg});
                end
            end
            default: ;
        endcase

        if (cfg_we) begin
            pool_next   = cfg_sat;
            clr_next    = '0;
            id_cnt_next = (ID_WIDTH+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            pool_reg    <= ORD_W'(POOL_RESET > TOP_ORDER ? TOP_ORDER : POOL_RESET);
            clr_reg     <= '0;
            id_cnt_reg  <= (ID_WIDTH+1)'(1);
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pool_reg    <= pool_next;
            clr_reg     <= clr_next;
            id_cnt_reg  <= id_cnt_next;
            rd_vld_reg  <= rd_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        req_reg        <= req_next;
        blk_reg        <= blk_next;
        base_reg       <= base_next;
        bud_reg        <= bud_next;
        ord_reg        <= ord_next;
        walk_reg       <= walk_next;
        prev_reg       <= prev_next;
        scan_reg       <= scan_next;
        rd_page_reg    <= rd_page_next;
        rid_reg        <= rid_next;
        is_free_reg    <= is_free_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_addr_reg   <= res_addr_next;
        out_data_reg   <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= TOP_ORDER; i++) begin
                head_reg[i] <= (i == POOL_RESET) ? '0 : NIL_PAGE;
            end
        end else if (cfg_we) begin
            for (int i = 0; i <= TOP_ORDER; i++) begin
                head_reg[i] <= (ORD_W'(i) == cfg_sat) ? '0 : NIL_PAGE;
            end
        end else if (head_we) begin
            head_reg[head_widx] <= head_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (nxt_we) begin
            nxt_mem[nxt_waddr] <= nxt_wdata;
        end
        nxt_rd_reg <= nxt_mem[nxt_raddr];
    end

    always_ff @(posedge aclk) begin
        if (blk_we) begin
            blk_mem[blk_waddr] <= blk_wdata;
        end
        blk_rd_reg <= blk_mem[scan_reg[PAGE_W-1:0]];
    end

endmodule

### src/bpa_checker.sv
// Port-level checks for the buddy page allocator, bound to the top level.
module bpa_checker import bpa_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             cfg_we
);

    a_reset_blocks_input: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready right after reset");

    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_tready)
        else $error("input ready right after config write");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != STAT_OK) |-> (m_tdata[33:2] == '0))
        else $error("error beat carries id or address");

endmodule

bind buddy_page_allocator_core bpa_checker u_bpa_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we)
);

### bench/buddy_page_allocator_checker.sv
// Checker for the buddy page allocator: predicts each result and compares it.
`timescale 1ns / 100ps
module buddy_page_allocator_checker import bpa_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    output int               fail_count,
    output int               pending
);
    logic [LINK_W-1:0]   head_of [0:TOP_ORDER];
    logic [LINK_W-1:0]   next_of [0:POOL_PAGES-1];
    logic [ID_WIDTH-1:0] id_of   [0:POOL_PAGES-1];
    int                  ord_of  [0:POOL_PAGES-1];
    bit                  live    [0:POOL_PAGES-1];
    longint              next_id;
    int                  pool_ord;
    logic [OUT_W-1:0]    answers [$];

    assign pending = answers.size();

    function automatic void reinit_pool(int ord);
        pool_ord = ord > TOP_ORDER ? TOP_ORDER : ord;
        for (int i = 0; i <= TOP_ORDER; i++) head_of[i] = NIL_PAGE;
        for (int i = 0; i < POOL_PAGES; i++) begin
            next_of[i] = NIL_PAGE;
            live[i] = 0;
            id_of[i] = '0;
            ord_of[i] = 0;
        end
        head_of[pool_ord] = '0;
        next_id = 1;
    endfunction

    function automatic bit take_from_list(int ord, int page);
        int prev;
        int cur;
        prev = -1;
        cur = head_of[ord];
        while (cur != NIL_PAGE) begin
            if (cur == page) begin
                if (prev < 0) head_of[ord] = next_of[cur];
                else next_of[prev] = next_of[cur];
                next_of[cur] = NIL_PAGE;
                return 1;
            end
            prev = cur;
            cur = next_of[cur];
        end
        return 0;
    endfunction

    function automatic int page_of_id(logic [ID_WIDTH-1:0] id);
        for (int p = 0; p < POOL_PAGES; p++)
            if (live[p] && id_of[p] == id) return p;
        return -1;
    endfunction

    function automatic logic [OUT_W-1:0] allocator_answer(logic [IN_W-1:0] beat);
        logic [1:0]          op;
        logic [SIZE_W-1:0]   size;
        logic [ID_WIDTH-1:0] rid;
        stat_t               st;
        logic [15:0]         bid;
        logic [15:0]         addr;
        longint              pages;
        int                  req;
        int                  cur;
        int                  blk;
        int                  base;
        int                  bud;
        int                  pg;
        op = beat[1:0];
        size = beat[25:2];
        rid = beat[41:26];
        st = STAT_OK;
        bid = '0;
        addr = '0;
        if (op == OP_ALLOC) begin
            if (size == 0) st = STAT_NOFIT;
            else begin
                pages = (longint'(size) + PAGE_BYTES - 1) / PAGE_BYTES;
                req = 0;
                while ((longint'(1) << req) < pages) req++;
                if (req > pool_ord) st = STAT_NOFIT;
                else if (next_id > (1 << ID_WIDTH) - 1) st = STAT_NOIDS;
                else begin
                    cur = req;
                    while (cur <= pool_ord && head_of[cur] == NIL_PAGE) cur++;
                    if (cur > pool_ord) st = STAT_NOFIT;
                    else begin
                        blk = head_of[cur];
                        head_of[cur] = next_of[blk];
                        next_of[blk] = NIL_PAGE;
                        while (cur > req) begin
                            cur--;
                            next_of[blk + (1 << cur)] = head_of[cur];
                            head_of[cur] = LINK_W'(blk + (1 << cur));
                        end
                        live[blk] = 1;
                        id_of[blk] = next_id[15:0];
                        ord_of[blk] = req;
                        bid = next_id[15:0];
                        next_id++;
                        addr = 16'(blk * PAGE_BYTES);
                    end
                end
            end
        end else if (op == OP_FREE) begin
            pg = page_of_id(rid);
            if (pg < 0) st = STAT_BADID;
            else begin
                base = pg;
                cur = ord_of[pg];
                live[pg] = 0;
                while (cur < pool_ord) begin
                    bud = base ^ (1 << cur);
                    if (!take_from_list(cur, bud)) break;
                    if (bud < base) base = bud;
                    cur++;
                end
                next_of[base] = head_of[cur];
                head_of[cur] = LINK_W'(base);
            end
        end else if (op == OP_QUERY) begin
            pg = page_of_id(rid);
            if (pg < 0) st = STAT_BADID;
            else addr = 16'(pg * PAGE_BYTES);
        end else st = STAT_NOFIT;
        return OUT_W'({addr, bid, st});
    endfunction

    always @(posedge aclk) begin
        logic [OUT_W-1:0] want;
        if (!aresetn) begin
            reinit_pool(POOL_RESET);
            answers.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) reinit_pool(int'(cfg_wdata));
            if (s_tvalid && s_tready) answers.push_back(allocator_answer(s_tdata));
            if (m_tvalid && m_tready) begin
                if (answers.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %h",
                        $time, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = answers.pop_front();
                    if (want[1:0] !== m_tdata[1:0] || want[17:2] !== m_tdata[17:2]
                        || want[33:18] !== m_tdata[33:18] || m_tdata[39:34] !== '0) begin
                        $display({"%0t: mismatch, expected st=%0d id=%h addr=%h, ",
                            "actual st=%0d id=%h addr=%h"},
                            $time, want[1:0], want[17:2], want[33:18],
                            m_tdata[1:0], m_tdata[17:2], m_tdata[33:18]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### bench/buddy_page_allocator_core_tb.sv
// Testbench top for the buddy page allocator: stimulus, idling and verdict.
`timescale 1ns / 100ps
module buddy_page_allocator_core_tb import bpa_pkg::*;;
    logic             aclk = 0;
    logic             aresetn = 0;
    logic             s_tvalid = 0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 0;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_we = 0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    int               fail_count;
    int               pending;
    int               cycle_count = 0;
    int               hold_off = 0;
    bit               long_stall = 0;
    bit               long_taken = 0;
    int               live_ids [$];
    int               last_id = 0;

    always #10 aclk = ~aclk;

    buddy_page_allocator_core i_dut (.*);

    buddy_page_allocator_checker i_checker (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1500000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        int gap;
        if (long_stall && !long_taken) begin
            m_tready   <= 0;
            hold_off   <= 300;
            long_taken <= 1;
        end else if (hold_off > 0) begin
            m_tready <= 0;
            hold_off <= hold_off - 1;
        end else if (!m_tready || !m_tvalid) begin
            m_tready <= 1;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                m_tready <= 0;
                hold_off <= gap;
            end
        end
    end

    task automatic send_beat(logic [1:0] op, logic [23:0] size, logic [15:0] rid, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {6'd0, rid, size, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == OP_ALLOC) last_id++;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (1100) @(posedge aclk);
    endtask

    task automatic set_pool(logic [3:0] ord);
        drain();
        cfg_we <= 1;
        cfg_wdata <= ord;
        @(posedge aclk);
        cfg_we <= 0;
        last_id = 0;
        live_ids.delete();
    endtask

    function automatic logic [23:0] rand_size();
        case ($urandom_range(0, 5))
            0: return 24'($urandom);
            1: return 24'($urandom_range(1, 64));
            default: return 24'($urandom_range(1, 64 * 16));
        endcase
    endfunction

    task automatic random_ops(int n, bit fast);
        int k;
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 5 || live_ids.size() == 0) begin
                send_beat(OP_ALLOC, rand_size(), 16'($urandom), fast);
                live_ids.push_back(last_id);
            end else if (pick < 8) begin
                k = $urandom_range(0, live_ids.size() - 1);
                send_beat(OP_FREE, 24'($urandom), 16'(live_ids[k]), fast);
                live_ids.delete(k);
            end else if (pick == 8) begin
                k = $urandom_range(0, live_ids.size() - 1);
                send_beat(OP_QUERY, 24'($urandom), 16'(live_ids[k]), fast);
            end else begin
                send_beat(2'($urandom), 24'($urandom), 16'($urandom), fast);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        // directed: size edges, every op, bad ids, unused op
        send_beat(OP_ALLOC, 24'd0, 16'd0, 0);
        send_beat(OP_ALLOC, 24'hFFFFFF, 16'hFFFF, 0);
        send_beat(OP_ALLOC, 24'd1, 16'd0, 0);
        send_beat(OP_ALLOC, 24'd65, 16'd0, 0);
        send_beat(OP_ALLOC, 24'd65536, 16'd0, 0);
        send_beat(OP_ALLOC, 24'd16384, 16'd0, 0);
        send_beat(OP_QUERY, 24'd0, 16'd2, 0);
        send_beat(OP_QUERY, 24'd0, 16'd0, 0);
        send_beat(OP_FREE, 24'd0, 16'hFFFF, 0);
        send_beat(OP_FREE, 24'd0, 16'd1, 0);
        send_beat(OP_FREE, 24'd0, 16'd2, 0);
        send_beat(OP_FREE, 24'd0, 16'd4, 0);
        send_beat(OP_FREE, 24'd0, 16'd2, 0);
        send_beat(2'd3, 24'hFFFFFF, 16'hFFFF, 0);
        set_pool(4'd0);
        send_beat(OP_ALLOC, 24'd64, 16'd0, 0);
        send_beat(OP_ALLOC, 24'd1, 16'd0, 0);
        send_beat(OP_FREE, 24'd0, 16'd1, 0);
        set_pool(4'd15);
        random_ops(150, 0);
        set_pool(4'd3);
        // long stall on the result side while input keeps coming
        long_stall <= 1;
        random_ops(100, 1);
        set_pool(4'd5);
        random_ops(150, 0);
        set_pool(4'd10);
        random_ops(200, 0);
        drain();
        if (fail_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule

### filelist.f
src/bpa_pkg.sv
src/bpa_front.sv
src/bpa_back.sv
src/buddy_page_allocator_core.sv
src/bpa_checker.sv
bench/buddy_page_allocator_checker.sv
bench/buddy_page_allocator_core_tb.sv
